// ----- hdl/trc_pkg.sv -----
// package for the trial division prime classifier
// shared link and control types for the divisor cell chain, register map constants
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

  // configuration port layout
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_VALUE = 1'b0;

  // reset value of the candidate limit
  localparam int MAX_VALUE_RESET = 10000;

  // test token handed from cell to cell
  typedef struct packed {
    logic tok;      // token is at this position
    logic divided;  // some earlier cell divides the candidate
    logic covered;  // some earlier cell holds a prime above the root
  } trc_link_t;

  // per-request control broadcast to all cells
  typedef struct packed {
    logic commit;   // in-order request retires, advance remainders
    logic store;    // the candidate is a new prime, first free cell takes it
  } trc_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/trc_if.sv -----
// valid/ready channel interfaces for candidates and results
// depends on nothing; widths follow the VALUE_BITS parameter
`timescale 1ns / 1ps
`default_nettype none

interface trc_cand_if #(
  parameter int VALUE_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface trc_res_if #(
  parameter int VALUE_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic                  gap_valid;
  logic [VALUE_BITS-1:0] gap_low;
  logic [VALUE_BITS-1:0] gap_high;
  logic [VALUE_BITS:0]   open_gap_low;
  logic                  order_error;
  logic                  table_full;

  modport source (output valid, output is_prime, output gap_valid, output gap_low,
                  output gap_high, output open_gap_low, output order_error,
                  output table_full, input ready);
  modport sink   (input valid, input is_prime, input gap_valid, input gap_low,
                  input gap_high, input open_gap_low, input order_error,
                  input table_full, output ready);
endinterface

`default_nettype wire

// ----- hdl/trc_cell.sv -----
// one divisor cell: holds a stored prime and the expected candidate modulo it
// depends on trc_pkg for the link and control types
`timescale 1ns / 1ps
`default_nettype none

module trc_cell
  import trc_pkg::*;
#(
  parameter int VALUE_BITS = 20,
  parameter int ROOT_BITS  = (VALUE_BITS + 1) / 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire trc_cell_ctrl_t        ctrl,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [ROOT_BITS-1:0]  root,
  input  wire logic                  prev_valid,
  output logic                       valid,
  input  wire trc_link_t             link_in,
  output trc_link_t                  link_out
);

  logic [VALUE_BITS-1:0] prime;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] rem_inc;
  logic [VALUE_BITS-1:0] root_ext;
  logic                  load;
  logic                  hit;
  logic                  over;

  // first free cell takes a new prime
  assign load     = ctrl.commit && ctrl.store && prev_valid && !valid;
  assign rem_inc  = rem + VALUE_BITS'(1);
  assign root_ext = VALUE_BITS'(root);
  assign hit      = valid && (rem == '0) && (prime <= root_ext);
  assign over     = valid && (prime > root_ext);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  // prime and running remainder of the next expected candidate
  always_ff @(posedge clk) begin
    if (load) begin
      prime <= value;
      rem   <= VALUE_BITS'(1);
    end else if (ctrl.commit && valid) begin
      rem <= (rem_inc == prime) ? '0 : rem_inc;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_in.tok;
    end
    link_out.divided <= link_in.divided | hit;
    link_out.covered <= link_in.covered | over;
  end

endmodule

`default_nettype wire

// ----- hdl/trc_sqrt.sv -----
// iterative floor square root, one root bit per cycle
// depends on trc_pkg only through the shared import style
`timescale 1ns / 1ps
`default_nettype none

module trc_sqrt
  import trc_pkg::*;
#(
  parameter int VALUE_BITS = 20,
  parameter int ROOT_BITS  = (VALUE_BITS + 1) / 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       done,
  output logic [ROOT_BITS-1:0]       root
);

  localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

  logic [VALUE_BITS-1:0] rest;
  logic [VALUE_BITS:0]   acc;
  logic [VALUE_BITS-1:0] bitw;
  logic [CNT_BITS-1:0]   cnt;
  logic                  running;
  logic [VALUE_BITS:0]   trial;
  logic                  fits;

  assign trial = acc + {1'b0, bitw};
  assign fits  = {1'b0, rest} >= trial;
  assign root  = acc[ROOT_BITS-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !start && running && (cnt == CNT_BITS'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_BITS'(ROOT_BITS);
      end else if (running) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rest <= value;
      acc  <= '0;
      bitw <= VALUE_BITS'(1) << (2 * (ROOT_BITS - 1));
    end else if (running) begin
      if (fits) begin
        rest <= rest - trial[VALUE_BITS-1:0];
        acc  <= (acc >> 1) + {1'b0, bitw};
      end else begin
        acc <= acc >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/trial_division_prime_classifier_top.sv -----
// in-order request: from accept to result through the bit-serial square root, the token walk
// through the divisor cell chain and the result register
// out-of-order request: goes straight to the result register, no state change
// one request at a time; the next is accepted as soon as the result is registered
// synchronous reset: empty prime store, last prime 1, expected candidate 2, limit 10000
// depends on trc_pkg, trc_if, trc_sqrt, trc_cell
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_classifier_top
  import trc_pkg::*;
#(
  parameter int STORE_DEPTH = 32,
  parameter int VALUE_BITS  = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  trc_cand_if.sink                      candidates,
  trc_res_if.source                     results,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_WALK, S_DONE} state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] max_value;
  logic [VALUE_BITS-1:0] cand;
  logic                  order_bad;
  logic [ROOT_BITS-1:0]  root_q;
  logic                  divided;
  logic                  covered;
  logic                  launch;
  logic [VALUE_BITS-1:0] last_prime;
  logic [VALUE_BITS:0]   expected_next;
  logic [VALUE_BITS-1:0] top_prime;
  logic                  res_valid;

  logic                  accept;
  logic                  in_order;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [ROOT_BITS-1:0]  sqrt_root;
  logic                  retire;
  logic                  in_range;
  logic                  prime_w;
  logic                  full_w;
  logic [VALUE_BITS:0]   lp_inc;
  logic                  gap_w;
  logic [VALUE_BITS-1:0] new_lp;
  logic                  store_full;
  trc_cell_ctrl_t        cell_ctrl;
  trc_link_t             links [STORE_DEPTH+1];
  logic [STORE_DEPTH:0]  chain_valid;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_VALUE) begin
      prdata = APB_DATA_BITS'(max_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= VALUE_BITS'(MAX_VALUE_RESET);
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_VALUE) begin
      max_value <= pwdata[VALUE_BITS-1:0];
    end
  end

  // request intake
  assign candidates.ready = (state == S_IDLE);
  assign accept           = candidates.valid && candidates.ready;
  assign in_order         = {1'b0, candidates.candidate} == expected_next;
  assign sqrt_start       = accept && in_order;

  trc_sqrt #(
    .VALUE_BITS (VALUE_BITS),
    .ROOT_BITS  (ROOT_BITS)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (candidates.candidate),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // classification of the finished request
  assign retire     = (state == S_DONE) && (!res_valid || results.ready);
  assign store_full = chain_valid[STORE_DEPTH];
  assign in_range   = cand <= max_value;
  assign prime_w    = !order_bad && in_range && !divided;
  assign full_w     = prime_w && !covered && (top_prime < VALUE_BITS'(root_q));
  assign lp_inc     = {1'b0, last_prime} + (VALUE_BITS + 1)'(1);
  assign gap_w      = prime_w && ({1'b0, cand} > lp_inc);
  assign new_lp     = prime_w ? cand : last_prime;

  assign cell_ctrl.commit = retire && !order_bad;
  assign cell_ctrl.store  = prime_w;

  // divisor cell chain
  assign links[0]       = '{tok: launch, divided: 1'b0, covered: 1'b0};
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_chain
    trc_cell #(
      .VALUE_BITS (VALUE_BITS),
      .ROOT_BITS  (ROOT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .value      (cand),
      .root       (root_q),
      .prev_valid (chain_valid[i]),
      .valid      (chain_valid[i+1]),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  // sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      launch        <= 1'b0;
      res_valid     <= 1'b0;
      last_prime    <= VALUE_BITS'(1);
      expected_next <= (VALUE_BITS + 1)'(2);
      top_prime     <= VALUE_BITS'(1);
    end else begin
      launch <= (state == S_ROOT) && sqrt_done;
      if (retire) begin
        res_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cand      <= candidates.candidate;
            order_bad <= !in_order;
            state     <= in_order ? S_ROOT : S_DONE;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            root_q <= sqrt_root;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (links[STORE_DEPTH].tok) begin
            divided <= links[STORE_DEPTH].divided;
            covered <= links[STORE_DEPTH].covered;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (retire) begin
            results.is_prime         <= prime_w;
            results.gap_valid        <= gap_w;
            results.gap_low          <= gap_w ? lp_inc[VALUE_BITS-1:0] : '0;
            results.gap_high         <= gap_w ? cand - VALUE_BITS'(1) : '0;
            results.open_gap_low     <= {1'b0, new_lp} + (VALUE_BITS + 1)'(1);
            results.order_error      <= order_bad;
            results.table_full       <= full_w;
            if (!order_bad) begin
              expected_next <= {1'b0, cand} + (VALUE_BITS + 1)'(1);
              last_prime    <= new_lp;
              if (prime_w && !store_full) begin
                top_prime <= cand;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid = res_valid;

endmodule

`default_nettype wire
